// File: rtl/wor_pkg.sv
// shared constants and types of the winograd output requantizer
// no dependencies; imported by every module under rtl
package wor_pkg;

    // field widths
    localparam int DATA_W    = 32;
    localparam int RES_W     = 8;
    localparam int OUT_W     = 8;
    localparam int LANES     = 4;
    localparam int ROW_CNT_W = 2;

    // q8.24 fixed point
    localparam int SCALE_FRAC_BITS = 24;

    // product and accumulation widths
    localparam int PROD_W  = 2 * DATA_W;
    localparam int RPROD_W = RES_W + DATA_W + 1;
    localparam int SUM_W   = 50;

    // scaled value clamp, keeps sign and int8 saturation
    localparam logic signed [PROD_W-1:0] PROD_LIMIT = PROD_W'(64'sd1 <<< 48);
    localparam logic signed [SUM_W-1:0]  SUM_LIMIT  = SUM_W'(64'sd1 <<< 48);

    // truncation toward zero: add this to negative values before the shift
    localparam logic signed [SUM_W-1:0] TRUNC_ADD = SUM_W'((64'sd1 <<< SCALE_FRAC_BITS) - 1);

    // int8 saturation bounds
    localparam logic signed [SUM_W-SCALE_FRAC_BITS-1:0] SAT_MAX =
        (SUM_W-SCALE_FRAC_BITS)'(127);
    localparam logic signed [SUM_W-SCALE_FRAC_BITS-1:0] SAT_MIN =
        (SUM_W-SCALE_FRAC_BITS)'(-128);

    // last row of the 4x4 product tile
    localparam logic [ROW_CNT_W-1:0] ROW_LAST = 2'd3;

    // relu mode codes
    localparam logic [1:0] RELU_NONE = 2'd0;
    localparam logic [1:0] RELU_PRE  = 2'd1;
    localparam logic [1:0] RELU_POST = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESIDUAL_EN = 1'b1;

    // one finished tile after the output transform
    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] acc;
        logic [DATA_W-1:0]            scale;
        logic [DATA_W-1:0]            rscale;
        logic [LANES-1:0][RES_W-1:0]  res;
    } wor_tile_t;

    // lane stage load enables
    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
    } wor_lane_ctl_t;

endpackage

// File: rtl/wor_tile_accum.sv
// row accumulation and 2x2 output transform of the product tile
// depends on wor_pkg
module wor_tile_accum
    import wor_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [LANES-1:0][DATA_W-1:0] row,
    input  logic [DATA_W-1:0]            bias,
    input  logic [DATA_W-1:0]            scale,
    input  logic [DATA_W-1:0]            rscale,
    input  logic [LANES-1:0][RES_W-1:0]  res,
    input  logic                         down_ready,
    output logic                         tile_valid,
    output wor_tile_t                    tile
);

    logic [ROW_CNT_W-1:0]         row_count_reg, row_count_next;
    logic [LANES-1:0][DATA_W-1:0] top_sum_reg, top_sum_next;
    logic [LANES-1:0][DATA_W-1:0] bot_sum_reg, bot_sum_next;

    // capture stage: tile sums after the fourth row
    logic                         v0_reg, v0_next;
    logic [LANES-1:0][DATA_W-1:0] s0_top_reg, s0_bot_reg;
    logic [DATA_W-1:0]            s0_bias_reg, s0_scale_reg, s0_rscale_reg;
    logic [LANES-1:0][RES_W-1:0]  s0_res_reg;

    // transform stage
    logic      v1_reg, v1_next;
    wor_tile_t s1_reg, s1_next;

    logic in_fire, last_row, rdy0, rdy1;

    // handshake
    assign rdy1     = !v1_reg || down_ready;
    assign rdy0     = !v0_reg || rdy1;
    assign last_row = (row_count_reg == ROW_LAST);
    assign in_stall = last_row && !rdy0;
    assign in_fire  = in_valid && !in_stall;

    // row sums, 32-bit wrap
    always_comb
    begin
        top_sum_next = top_sum_reg;
        bot_sum_next = bot_sum_reg;
        for (int i = 0; i < LANES; i++)
        begin
            case (row_count_reg)
                2'd0:
                begin
                    top_sum_next[i] = row[i];
                    bot_sum_next[i] = '0;
                end
                2'd1:
                begin
                    top_sum_next[i] = top_sum_reg[i] + row[i];
                    bot_sum_next[i] = row[i];
                end
                2'd2:
                begin
                    top_sum_next[i] = top_sum_reg[i] + row[i];
                    bot_sum_next[i] = bot_sum_reg[i] - row[i];
                end
                default:
                begin
                    bot_sum_next[i] = bot_sum_reg[i] + row[i];
                end
            endcase
        end
    end

    // column transform of the captured tile
    always_comb
    begin
        s1_next.acc[0] = s0_top_reg[0] + s0_top_reg[1] + s0_top_reg[2] + s0_bias_reg;
        s1_next.acc[1] = s0_top_reg[1] - s0_top_reg[2] + s0_top_reg[3] + s0_bias_reg;
        s1_next.acc[2] = s0_bot_reg[0] + s0_bot_reg[1] + s0_bot_reg[2] + s0_bias_reg;
        s1_next.acc[3] = s0_bot_reg[1] - s0_bot_reg[2] + s0_bot_reg[3] + s0_bias_reg;
        s1_next.scale  = s0_scale_reg;
        s1_next.rscale = s0_rscale_reg;
        s1_next.res    = s0_res_reg;
    end

    // control next state
    always_comb
    begin
        row_count_next = row_count_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        if (in_fire)
        begin
            row_count_next = row_count_reg + 1'b1;
        end
        if (rdy0)
        begin
            v0_next = in_fire && last_row;
        end
        if (rdy1)
        begin
            v1_next = v0_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            v0_reg        <= v0_next;
            v1_reg        <= v1_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            top_sum_reg <= top_sum_next;
            bot_sum_reg <= bot_sum_next;
        end
        if (in_fire && last_row)
        begin
            s0_top_reg    <= top_sum_reg;
            s0_bot_reg    <= bot_sum_next;
            s0_bias_reg   <= bias;
            s0_scale_reg  <= scale;
            s0_rscale_reg <= rscale;
            s0_res_reg    <= res;
        end
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
    end

    assign tile_valid = v1_reg;
    assign tile       = s1_reg;

    // every accepted row moves the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> row_count_reg == $past(row_count_reg) + 2'd1)
        else $error("row counter skipped on accepted row");

    // counter holds without a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(row_count_reg))
        else $error("row counter moved without a transaction");

    // fourth row always lands in the capture stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_row) |=> v0_reg)
        else $error("fourth row lost at capture stage");

    // only the fourth row can be held off
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> last_row && v0_reg && v1_reg)
        else $error("stall raised with room in the tile stages");

endmodule

// File: rtl/wor_lane.sv
// one requantization lane: scale multiply, clamp, relu, residual, int8 saturation
// depends on wor_pkg
module wor_lane
    import wor_pkg::*;
(
    input  logic                     clk,
    input  wor_lane_ctl_t            ctl,
    input  logic [DATA_W-1:0]        acc,
    input  logic [DATA_W-1:0]        scale,
    input  logic [DATA_W-1:0]        rscale,
    input  logic [RES_W-1:0]         res,
    input  logic [1:0]               relu_mode,
    input  logic                     residual_enable,
    output logic signed [OUT_W-1:0]  q
);

    logic signed [DATA_W-1:0]  acc_s;
    logic signed [DATA_W:0]    scale_s, rscale_s;
    logic signed [RES_W-1:0]   res_s;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [RPROD_W-1:0] rprod_reg, rprod_next;
    logic signed [SUM_W-1:0]   clamp_val, rterm, sum_reg, sum_next;
    logic signed [SUM_W-1:0]   post_val, trunc_in;
    logic signed [SUM_W-SCALE_FRAC_BITS-1:0] quot;

    // multiply stage, unsigned scales as positive signed operands
    always_comb
    begin
        acc_s      = $signed(acc);
        res_s      = $signed(res);
        scale_s    = $signed({1'b0, scale});
        rscale_s   = $signed({1'b0, rscale});
        prod_next  = PROD_W'(acc_s * scale_s);
        rprod_next = RPROD_W'(res_s * rscale_s);
    end

    // clamp, relu before residual, residual add
    always_comb
    begin
        if (prod_reg > PROD_LIMIT)
        begin
            clamp_val = SUM_LIMIT;
        end
        else if (prod_reg < -PROD_LIMIT)
        begin
            clamp_val = -SUM_LIMIT;
        end
        else
        begin
            clamp_val = SUM_W'(prod_reg);
        end
        if (relu_mode == RELU_PRE && clamp_val < 0)
        begin
            clamp_val = '0;
        end
        rterm    = residual_enable ? SUM_W'(rprod_reg) : '0;
        sum_next = clamp_val + rterm;
    end

    // relu after residual, truncate toward zero, saturate
    always_comb
    begin
        post_val = sum_reg;
        if (relu_mode == RELU_POST && sum_reg < 0)
        begin
            post_val = '0;
        end
        trunc_in = post_val + ((post_val < 0) ? TRUNC_ADD : '0);
        quot     = (SUM_W-SCALE_FRAC_BITS)'(trunc_in >>> SCALE_FRAC_BITS);
        if (quot > SAT_MAX)
        begin
            q = OUT_W'(SAT_MAX);
        end
        else if (quot < SAT_MIN)
        begin
            q = OUT_W'(SAT_MIN);
        end
        else
        begin
            q = quot[OUT_W-1:0];
        end
    end

    // lane pipeline registers
    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            prod_reg  <= prod_next;
            rprod_reg <= rprod_next;
        end
        if (ctl.ld_sum)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// File: rtl/winograd_output_requant_unit.sv
// top level of the winograd f(2x2,3x3) output transform with int8 requantization
// depends on wor_pkg, wor_tile_accum and wor_lane
//
// usage
//   input channel (in_valid / in_stall): one row of the 4x4 int32 product tile per
//   transaction; bias, scales and residuals are taken with the fourth row only.
//   output channel (out_valid / out_stall): one transaction of four saturated int8
//   outputs per tile, none for the first three rows.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 relu_mode, 1 residual_enable); write only while the block is idle.
// throughput: one row per cycle while in_stall is low; four lanes requantize the 2x2 outputs
//   side by side, so the lanes never slow the row stream unless the output stalls.
// order: the edge that takes the fourth row captures the tile; the tile then passes
//   the column transform, lane multiply, lane add and output register before out_valid rises.
// stalls: rows one to three are always taken; the fourth row is held off only
//   when all tile stages are full behind a stalled output. The output register
//   holds its data while out_valid and out_stall are both high.
// reset: row counter returns to the first row, pipeline empties, relu_mode and
//   residual_enable clear to zero.
module winograd_output_requant_unit
    import wor_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] acc_col0,
    input  logic signed [DATA_W-1:0] acc_col1,
    input  logic signed [DATA_W-1:0] acc_col2,
    input  logic signed [DATA_W-1:0] acc_col3,
    input  logic signed [DATA_W-1:0] bias_value,
    input  logic [DATA_W-1:0]        scale_q,
    input  logic [DATA_W-1:0]        residual_scale_q,
    input  logic signed [RES_W-1:0]  residual_00,
    input  logic signed [RES_W-1:0]  residual_01,
    input  logic signed [RES_W-1:0]  residual_10,
    input  logic signed [RES_W-1:0]  residual_11,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  out_00,
    output logic signed [OUT_W-1:0]  out_01,
    output logic signed [OUT_W-1:0]  out_10,
    output logic signed [OUT_W-1:0]  out_11
);

    logic [1:0] relu_mode_reg, relu_mode_next;
    logic       residual_enable_reg, residual_enable_next;

    logic                         tile_valid;
    wor_tile_t                    tile;
    logic [LANES-1:0][DATA_W-1:0] row;
    logic [LANES-1:0][RES_W-1:0]  res;

    logic                        v_prod_reg, v_prod_next;
    logic                        v_sum_reg, v_sum_next;
    logic                        out_valid_reg, out_valid_next;
    logic [LANES-1:0][OUT_W-1:0] out_data_reg;
    logic [LANES-1:0][OUT_W-1:0] lane_q;
    logic                        rdy_out, rdy_sum, rdy_prod;
    wor_lane_ctl_t               lane_ctl;

    // ready chain, a stage loads when empty or when it drains
    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy_sum  = !v_sum_reg || rdy_out;
    assign rdy_prod = !v_prod_reg || rdy_sum;

    assign lane_ctl.ld_prod = rdy_prod;
    assign lane_ctl.ld_sum  = rdy_sum;

    assign row = {acc_col3, acc_col2, acc_col1, acc_col0};
    assign res = {residual_11, residual_10, residual_01, residual_00};

    // row accumulation and output transform
    wor_tile_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row        (row),
        .bias       (bias_value),
        .scale      (scale_q),
        .rscale     (residual_scale_q),
        .res        (res),
        .down_ready (rdy_prod),
        .tile_valid (tile_valid),
        .tile       (tile)
    );

    // four requantization lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        wor_lane u_lane (
            .clk             (clk),
            .ctl             (lane_ctl),
            .acc             (tile.acc[g]),
            .scale           (tile.scale),
            .rscale          (tile.rscale),
            .res             (tile.res[g]),
            .relu_mode       (relu_mode_reg),
            .residual_enable (residual_enable_reg),
            .q               (lane_q[g])
        );
    end

    // configuration decode
    always_comb
    begin
        relu_mode_next       = relu_mode_reg;
        residual_enable_next = residual_enable_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RELU_MODE:   relu_mode_next       = cfg_data;
                CFG_RESIDUAL_EN: residual_enable_next = cfg_data[0];
                default:         ;
            endcase
        end
    end

    // pipeline valids
    always_comb
    begin
        v_prod_next    = rdy_prod ? tile_valid : v_prod_reg;
        v_sum_next     = rdy_sum  ? v_prod_reg : v_sum_reg;
        out_valid_next = rdy_out  ? v_sum_reg  : out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_mode_reg       <= RELU_NONE;
            residual_enable_reg <= 1'b0;
            v_prod_reg          <= 1'b0;
            v_sum_reg           <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            relu_mode_reg       <= relu_mode_next;
            residual_enable_reg <= residual_enable_next;
            v_prod_reg          <= v_prod_next;
            v_sum_reg           <= v_sum_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // merge stage: lane results into the output register
    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            out_data_reg <= lane_q;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_00    = out_data_reg[0];
    assign out_01    = out_data_reg[1];
    assign out_10    = out_data_reg[2];
    assign out_11    = out_data_reg[3];

    // a new result comes only from a filled lane sum stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v_sum_reg))
        else $error("output valid without lane result");

    // a held lane result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_sum_reg && !rdy_sum) |=> v_sum_reg)
        else $error("lane sum stage dropped a tile");

    // a held product stage is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_prod_reg && !rdy_prod) |=> v_prod_reg)
        else $error("lane product stage dropped a tile");

endmodule

// File: sim/winograd_output_requant_unit_tb.sv
// self-checking testbench for winograd_output_requant_unit
// depends on rtl/wor_pkg.sv and the rtl of the unit; directed tiles, then random tiles per setting
`timescale 1ns / 1ps

module winograd_output_requant_unit_tb;
    import wor_pkg::*;

    // one row of the product tile as offered on the input channel
    // packed lanes: index 0 is column 0 / residual_00
    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] acc;
        logic [DATA_W-1:0]            bias;
        logic [DATA_W-1:0]            scale;
        logic [DATA_W-1:0]            rscale;
        logic [LANES-1:0][RES_W-1:0]  res;
    } tile_row_t;

    // four int8 outputs, index 0 is out_00, then out_01, out_10, out_11
    typedef logic [LANES-1:0][OUT_W-1:0] quad_t;

    // directed stimulus entry
    typedef struct packed {
        logic [1:0] relu;
        logic       res_en;
        tile_row_t  row;
        logic       typed;
        quad_t      want;
    } dir_entry_t;

    localparam logic [1:0] RELU_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] I32_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] I32_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] U32_MAX = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0100_0000;
    localparam logic [DATA_W-1:0] Q_HALF  = 32'h0080_0000;

    localparam longint SCALED_LIMIT = 64'sd1 <<< 48;

    localparam int PIPE_SLACK     = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int TILES_PER_PH   = 26;
    localparam int LONG_HOLD      = 200;

    // leading rows carry junk in the fourth-row-only fields
    localparam tile_row_t JUNK_ROW = '{acc: '0, bias: I32_MIN, scale: U32_MAX,
                                       rscale: U32_MAX, res: {4{8'h80}}};

    // literals list lanes from the highest index down: {col3, col2, col1, col0}
    localparam int DIR_ROWS = 24;
    localparam dir_entry_t DIRECTED [DIR_ROWS] = '{
        // zero tile gives zero
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, '{acc: '0, bias: '0, scale: Q_ONE, rscale: '0, res: '0},
          1'b1, '0},
        // most negative bias at full scale: clamped product, saturates low
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, '{acc: '0, bias: I32_MIN, scale: U32_MAX, rscale: '0, res: '0},
          1'b1, {4{8'h80}}},
        // most positive bias at full scale, residual fields ignored while disabled
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, JUNK_ROW, 1'b0, '0},
        '{RELU_NONE, 1'b0, '{acc: '0, bias: I32_MAX, scale: U32_MAX, rscale: U32_MAX,
          res: {4{8'h80}}}, 1'b1, {4{8'h7f}}},
        // clamp before residual: zero plus residual extremes
        '{RELU_PRE, 1'b1, JUNK_ROW, 1'b0, '0},
        '{RELU_PRE, 1'b1, JUNK_ROW, 1'b0, '0},
        '{RELU_PRE, 1'b1, JUNK_ROW, 1'b0, '0},
        '{RELU_PRE, 1'b1, '{acc: '0, bias: I32_MIN, scale: U32_MAX, rscale: U32_MAX,
          res: {8'hff, 8'h00, 8'h80, 8'h7f}}, 1'b1, {8'h80, 8'h00, 8'h80, 8'h7f}},
        // clamp after residual: clamped product swamps the residual
        '{RELU_POST, 1'b1, JUNK_ROW, 1'b0, '0},
        '{RELU_POST, 1'b1, JUNK_ROW, 1'b0, '0},
        '{RELU_POST, 1'b1, JUNK_ROW, 1'b0, '0},
        '{RELU_POST, 1'b1, '{acc: '0, bias: I32_MIN, scale: U32_MAX, rscale: U32_MAX,
          res: {8'hff, 8'h00, 8'h80, 8'h7f}}, 1'b1, {4{8'h00}}},
        // unused relu code, column transform with wrap, half scale truncation
        '{RELU_UNUSED, 1'b0, '{acc: {32'd7, 32'hffff_fffd, 32'd5, 32'd1}, bias: '0,
          scale: '0, rscale: '0, res: '0}, 1'b0, '0},
        '{RELU_UNUSED, 1'b0, '{acc: {I32_MAX, 32'd2, 32'hffff_fff9, 32'd11}, bias: '0,
          scale: '0, rscale: '0, res: '0}, 1'b0, '0},
        '{RELU_UNUSED, 1'b0, '{acc: {32'd3, I32_MIN, 32'd13, 32'hffff_fffe}, bias: '0,
          scale: '0, rscale: '0, res: '0}, 1'b0, '0},
        '{RELU_UNUSED, 1'b0, '{acc: {32'hffff_fffb, 32'd9, 32'd4, 32'hffff_ffff},
          bias: 32'hffff_fffb, scale: Q_HALF, rscale: Q_ONE, res: {4{8'h01}}}, 1'b0, '0}
    };

    localparam string LANE_NAME [LANES] = '{"out_00", "out_01", "out_10", "out_11"};

    // clock, reset and block ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [DATA_W-1:0] acc_col0 = '0;
    logic signed [DATA_W-1:0] acc_col1 = '0;
    logic signed [DATA_W-1:0] acc_col2 = '0;
    logic signed [DATA_W-1:0] acc_col3 = '0;
    logic signed [DATA_W-1:0] bias_value = '0;
    logic [DATA_W-1:0] scale_q = '0;
    logic [DATA_W-1:0] residual_scale_q = '0;
    logic signed [RES_W-1:0] residual_00 = '0;
    logic signed [RES_W-1:0] residual_01 = '0;
    logic signed [RES_W-1:0] residual_10 = '0;
    logic signed [RES_W-1:0] residual_11 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] out_00;
    logic signed [OUT_W-1:0] out_01;
    logic signed [OUT_W-1:0] out_10;
    logic signed [OUT_W-1:0] out_11;

    // typed expectation travels with the offered row
    logic  row_typed = 1'b0;
    quad_t row_want = '0;

    // predictor state and register copies
    logic [1:0]        cur_relu = RELU_NONE;
    logic              cur_res_en = 1'b0;
    logic [1:0]        tile_row_pos = '0;
    logic [DATA_W-1:0] top_col_sum [LANES];
    logic [DATA_W-1:0] bottom_col_sum [LANES];

    quad_t pending_quads [$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    hold_len = 0;

    winograd_output_requant_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .acc_col0         (acc_col0),
        .acc_col1         (acc_col1),
        .acc_col2         (acc_col2),
        .acc_col3         (acc_col3),
        .bias_value       (bias_value),
        .scale_q          (scale_q),
        .residual_scale_q (residual_scale_q),
        .residual_00      (residual_00),
        .residual_01      (residual_01),
        .residual_10      (residual_10),
        .residual_11      (residual_11),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_00           (out_00),
        .out_01           (out_01),
        .out_10           (out_10),
        .out_11           (out_11)
    );

    always #10 clk = ~clk;

    // scale, clamp, optional relu and residual, truncate toward zero, saturate
    function automatic logic [OUT_W-1:0] requant_lane(logic [DATA_W-1:0] sum,
                                                      logic [DATA_W-1:0] scale,
                                                      logic [RES_W-1:0] res,
                                                      logic [DATA_W-1:0] rscale);
        longint p;
        longint q;
        p = longint'($signed(sum)) * longint'({32'd0, scale});
        if (p > SCALED_LIMIT)
            p = SCALED_LIMIT;
        if (p < -SCALED_LIMIT)
            p = -SCALED_LIMIT;
        if (cur_relu == RELU_PRE && p < 0)
            p = 0;
        if (cur_res_en)
            p = p + longint'($signed(res)) * longint'({32'd0, rscale});
        if (cur_relu == RELU_POST && p < 0)
            p = 0;
        q = p / (longint'(1) <<< SCALE_FRAC_BITS);
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return OUT_W'(q);
    endfunction

    // accumulate one row; returns 1 with the 2x2 outputs on the fourth row
    function automatic bit advance_tile(input tile_row_t r, output quad_t q);
        logic [DATA_W-1:0] a [LANES];
        q = '0;
        for (int i = 0; i < LANES; i++) begin
            case (tile_row_pos)
                2'd0:
                begin
                    top_col_sum[i] = r.acc[i];
                    bottom_col_sum[i] = '0;
                end
                2'd1:
                begin
                    top_col_sum[i] = top_col_sum[i] + r.acc[i];
                    bottom_col_sum[i] = r.acc[i];
                end
                2'd2:
                begin
                    top_col_sum[i] = top_col_sum[i] + r.acc[i];
                    bottom_col_sum[i] = bottom_col_sum[i] - r.acc[i];
                end
                default:
                begin
                    bottom_col_sum[i] = bottom_col_sum[i] + r.acc[i];
                end
            endcase
        end
        if (tile_row_pos != ROW_LAST) begin
            tile_row_pos = tile_row_pos + 2'd1;
            return 1'b0;
        end
        tile_row_pos = '0;
        a[0] = top_col_sum[0] + top_col_sum[1] + top_col_sum[2] + r.bias;
        a[1] = top_col_sum[1] - top_col_sum[2] + top_col_sum[3] + r.bias;
        a[2] = bottom_col_sum[0] + bottom_col_sum[1] + bottom_col_sum[2] + r.bias;
        a[3] = bottom_col_sum[1] - bottom_col_sum[2] + bottom_col_sum[3] + r.bias;
        for (int i = 0; i < LANES; i++)
            q[i] = requant_lane(a[i], r.scale, r.res[i], r.rscale);
        return 1'b1;
    endfunction

    // random row: mostly moderate values so outputs land inside int8
    function automatic tile_row_t random_row(int unsigned mode);
        tile_row_t r;
        r.res = $urandom;
        if (mode < 6) begin
            for (int i = 0; i < LANES; i++)
                r.acc[i] = DATA_W'($urandom_range(0, 128) - 64);
            r.bias = DATA_W'($urandom_range(0, 512) - 256);
            r.scale = DATA_W'($urandom_range(0, 1 << 23));
            r.rscale = DATA_W'($urandom_range(0, 1 << 24));
        end
        else if (mode < 8) begin
            for (int i = 0; i < LANES; i++)
                r.acc[i] = DATA_W'($signed($urandom) >>> $urandom_range(8, 20));
            r.bias = DATA_W'($signed($urandom) >>> $urandom_range(8, 20));
            r.scale = DATA_W'($urandom_range(0, 1 << 14));
            r.rscale = $urandom;
        end
        else begin
            for (int i = 0; i < LANES; i++)
                r.acc[i] = $urandom;
            r.bias = $urandom;
            r.scale = $urandom;
            r.rscale = $urandom;
        end
        return r;
    endfunction

    // offer one row, hold it until taken
    task automatic offer_row(tile_row_t r, logic typed, quad_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        acc_col0 <= r.acc[0];
        acc_col1 <= r.acc[1];
        acc_col2 <= r.acc[2];
        acc_col3 <= r.acc[3];
        bias_value <= r.bias;
        scale_q <= r.scale;
        residual_scale_q <= r.rscale;
        residual_00 <= r.res[0];
        residual_01 <= r.res[1];
        residual_10 <= r.res[2];
        residual_11 <= r.res[3];
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering until every pending tile result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_quads.size() != 0);
    endtask

    // write both registers once the block has gone quiet
    task automatic reconfigure(logic [1:0] relu, logic res_en);
        drain_results();
        repeat (PIPE_SLACK)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RELU_MODE;
        cfg_data <= relu;
        @(posedge clk);
        cfg_index <= CFG_RESIDUAL_EN;
        cfg_data <= CFG_DATA_W'(res_en);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_relu = relu;
        cur_res_en = res_en;
    endtask

    // input side: predict on every accepted row
    always @(posedge clk)
    begin : row_monitor
        tile_row_t r;
        quad_t q;
        if (rst_n && in_valid && !in_stall) begin
            r.acc = {acc_col3, acc_col2, acc_col1, acc_col0};
            r.bias = bias_value;
            r.scale = scale_q;
            r.rscale = residual_scale_q;
            r.res = {residual_11, residual_10, residual_01, residual_00};
            if (advance_tile(r, q)) begin
                if (row_typed)
                    q = row_want;
                pending_quads.push_back(q);
            end
        end
    end

    // output side: compare each transaction with the oldest pending tile
    always @(posedge clk)
    begin : quad_checker
        quad_t got;
        quad_t exp_q;
        if (rst_n && out_valid && !out_stall) begin
            got = {out_11, out_10, out_01, out_00};
            if (pending_quads.size() == 0) begin
                $error("output transaction with no tile pending: %0d %0d %0d %0d",
                       out_00, out_01, out_10, out_11);
                errors++;
            end
            else begin
                exp_q = pending_quads.pop_front();
                for (int i = 0; i < LANES; i++) begin
                    if (got[i] !== exp_q[i]) begin
                        $error("%s: expected %0d, got %0d", LANE_NAME[i],
                               $signed(exp_q[i]), $signed(got[i]));
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_len != 0) begin
                out_stall <= 1'b1;
                repeat (hold_len)
                    @(posedge clk);
                hold_len = 0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // main sequence
    initial begin
        int unsigned mode;
        int prof;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tiles
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (DIRECTED[k].relu != cur_relu || DIRECTED[k].res_en != cur_res_en)
                reconfigure(DIRECTED[k].relu, DIRECTED[k].res_en);
            offer_row(DIRECTED[k].row, DIRECTED[k].typed, DIRECTED[k].want);
        end

        // random tiles, one register setting and idle profile per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            reconfigure(2'(ph % 4), 1'(ph / 4));
            prof = (ph + ph / 4) % 4;
            case (prof)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 59; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            // long receiver hold-off while rows keep coming
            if (ph == 2)
                hold_len = LONG_HOLD;
            for (int t = 0; t < TILES_PER_PH; t++) begin
                mode = $urandom_range(9);
                // sender pause mid-phase until all results are back
                if (ph == 5 && t == TILES_PER_PH / 2)
                    drain_results();
                for (int r = 0; r < 4; r++)
                    offer_row(random_row(mode), 1'b0, '0);
            end
        end

        // wind down
        drain_results();
        repeat (PIPE_SLACK)
            @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
